[rtl/core/svl_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the state-variable lowpass filter.
package svl_pkg;

	typedef logic [2:0] step_t;

	localparam step_t STEP_IDLE = 3'd0;
	localparam step_t STEP_EMIT = 3'd3;
	localparam step_t STEP_LAST = 3'd5;

	typedef enum logic [1:0] {
		REG_FREQ = 2'd0,
		REG_DAMP = 2'd1,
		REG_GAIN = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		BR_NEXT,
		BR_WAIT_IN,
		BR_WAIT_OUT,
		BR_GOTO
	} branch_t;

	typedef enum logic [1:0] {
		CS_FREQ,
		CS_DAMP,
		CS_GAIN
	} coef_sel_t;

	typedef enum logic [1:0] {
		OS_BAND,
		OS_ACC,
		OS_SAMPLE
	} opnd_sel_t;

	typedef enum logic [2:0] {
		ALU_NOP,
		ALU_ACC_LOAD,
		ALU_LOW_ADD,
		ALU_ACC_SUB,
		ALU_BAND_ADD
	} alu_op_t;

	typedef struct packed {
		branch_t   branch;
		step_t     target;
		coef_sel_t coef;
		opnd_sel_t opnd;
		logic      mul_en;
		alu_op_t   alu;
		logic      emit;
	} ucode_t;

	typedef struct packed {
		ucode_t uc;
		logic   adv;
	} ctrl_t;

	localparam ucode_t UC_NOP = '{
		branch: BR_NEXT, target: STEP_IDLE, coef: CS_FREQ, opnd: OS_BAND,
		mul_en: 1'b0, alu: ALU_NOP, emit: 1'b0
	};

endpackage

[rtl/core/state_variable_lowpass.sv]
`timescale 1ns / 1ps
// Chamberlin state-variable lowpass filter, top level.
//
// One request on the sample channel (sample_valid, sample_stall, sample_in)
// carries one signed 16-bit sample; each produces one request on the result
// channel (result_valid, result_stall, sample_out), the lowpass output
// rounded and saturated to 16 bits.
// A six-step microcode program runs one shared 17 x STATE_WIDTH multiplier:
// gain*x, f*band, damp*band, then f*high after high is formed. A new sample
// is taken only when the program is back at its idle step.
// The result is registered at the emit step, once low has been formed.
// The output sits in a register; if it is still held by result_stall when
// the next result is ready, the program waits at that step. sample_stall is
// high whenever the program is not at its idle step. Coefficients are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while idle, which the block does not enforce. Index 0 freq_coef (1.14), 1
// damping (1.15), 2 input_gain (1.15). Reset clears both integrators, loads
// the coefficients with 1.0 and empties the output register.
module state_variable_lowpass #(
	parameter int STATE_WIDTH = 36
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic signed [15:0] sample_in,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [15:0] sample_out,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import svl_pkg::*;

	ctrl_t ctrl;
	logic  out_free;

	svl_sequencer u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.out_free     (out_free),
		.sample_stall (sample_stall),
		.ctrl         (ctrl)
	);

	svl_datapath #(
		.W (STATE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.sample_in    (sample_in),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.sample_out   (sample_out),
		.out_free     (out_free)
	);

endmodule

[rtl/core/svl_sequencer.sv]
`timescale 1ns / 1ps
// Microcode ROM and step counter that sequence the filter datapath.
module svl_sequencer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          sample_valid,
	input  logic          out_free,
	output logic          sample_stall,
	output svl_pkg::ctrl_t ctrl
);
	import svl_pkg::*;

	step_t  step_q;
	step_t  step_d;
	ucode_t uc;
	logic   adv;

	function automatic ucode_t rom_word(input step_t s);
		ucode_t w;
		w = UC_NOP;
		case (s)
			3'd0: begin
				// wait for a request, start gain * sample
				w.branch = BR_WAIT_IN;
				w.coef   = CS_GAIN;
				w.opnd   = OS_SAMPLE;
				w.mul_en = 1'b1;
			end
			3'd1: begin
				w.coef   = CS_FREQ;
				w.opnd   = OS_BAND;
				w.mul_en = 1'b1;
				w.alu    = ALU_ACC_LOAD;
			end
			3'd2: begin
				w.coef   = CS_DAMP;
				w.opnd   = OS_BAND;
				w.mul_en = 1'b1;
				w.alu    = ALU_LOW_ADD;
			end
			3'd3: begin
				// low is final here; hold until the output slot is free
				w.branch = BR_WAIT_OUT;
				w.alu    = ALU_ACC_SUB;
				w.emit   = 1'b1;
			end
			3'd4: begin
				w.coef   = CS_FREQ;
				w.opnd   = OS_ACC;
				w.mul_en = 1'b1;
			end
			3'd5: begin
				w.branch = BR_GOTO;
				w.target = STEP_IDLE;
				w.alu    = ALU_BAND_ADD;
			end
			default: begin
				w.branch = BR_GOTO;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

	always_comb begin
		uc = rom_word(step_q);
		unique case (uc.branch)
			BR_WAIT_IN:  adv = sample_valid;
			BR_WAIT_OUT: adv = out_free;
			default:     adv = 1'b1;
		endcase
		if (!adv) begin
			step_d = step_q;
		end else if (uc.branch == BR_GOTO) begin
			step_d = uc.target;
		end else begin
			step_d = step_q + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	assign sample_stall = (step_q != STEP_IDLE);
	assign ctrl.uc      = uc;
	assign ctrl.adv     = adv;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_LAST)
		else $error("step counter out of program");

	a_no_early_return: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != STEP_IDLE) |=> (step_q != STEP_IDLE) || ($past(step_q) == STEP_LAST))
		else $error("program returned to idle before its last step");

endmodule

[rtl/core/svl_datapath.sv]
`timescale 1ns / 1ps
// Shared multiplier, integrators, config registers and output register.
module svl_datapath #(
	parameter int W = 36
) (
	input  logic                clk,
	input  logic                arst_n,
	input  svl_pkg::ctrl_t      ctrl,
	input  logic signed [15:0]  sample_in,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                result_stall,
	output logic                result_valid,
	output logic signed [15:0]  sample_out,
	output logic                out_free
);
	import svl_pkg::*;

	localparam int PW = W + 17;
	localparam logic signed [PW-1:0] HALF14 = PW'(1) << 13;
	localparam logic signed [PW-1:0] HALF15 = PW'(1) << 14;
	localparam logic signed [W:0]    HALF16 = (W + 1)'(1) << 15;
	localparam logic signed [W:0]    SAT_HI = (W + 1)'(32767);
	localparam logic signed [W:0]    SAT_LO = ~SAT_HI;

	logic [14:0] freq_q;
	logic [15:0] damp_q;
	logic [15:0] gain_q;

	logic [W-1:0] low_q;
	logic [W-1:0] band_q;
	logic [W-1:0] acc_q;
	logic signed [PW-1:0] prod_q;

	logic [15:0]          coef;
	logic signed [W-1:0]  opnd;
	logic signed [PW-1:0] rnd14;
	logic signed [PW-1:0] rnd15;
	logic signed [W:0]    lo_r;
	logic signed [15:0]   sat;
	logic                 out_valid_q;
	logic signed [15:0]   out_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= 15'd16384;
			damp_q <= 16'd32768;
			gain_q <= 16'd32768;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FREQ: freq_q <= cfg_data[14:0];
				REG_DAMP: damp_q <= cfg_data;
				REG_GAIN: gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// operand select
	always_comb begin
		unique case (ctrl.uc.coef)
			CS_FREQ: coef = {1'b0, freq_q};
			CS_DAMP: coef = damp_q;
			CS_GAIN: coef = gain_q;
			default: coef = '0;
		endcase
		unique case (ctrl.uc.opnd)
			OS_BAND:   opnd = $signed(band_q);
			OS_ACC:    opnd = $signed(acc_q);
			OS_SAMPLE: opnd = {{(W-16){sample_in[15]}}, sample_in};
			default:   opnd = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv && ctrl.uc.mul_en) begin
			prod_q <= $signed({1'b0, coef}) * opnd;
		end
	end

	// round to nearest, ties up
	assign rnd14 = (prod_q + HALF14) >>> 14;
	assign rnd15 = (prod_q + HALF15) >>> 15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			band_q <= '0;
		end else if (ctrl.adv) begin
			case (ctrl.uc.alu)
				ALU_LOW_ADD:  low_q  <= low_q + rnd14[W-1:0];
				ALU_BAND_ADD: band_q <= band_q + rnd14[W-1:0];
				default: ;
			endcase
		end
	end

	// acc holds 2*gain*x, then high
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			case (ctrl.uc.alu)
				ALU_ACC_LOAD: acc_q <= {prod_q[W-2:0], 1'b0};
				ALU_ACC_SUB:  acc_q <= acc_q - rnd15[W-1:0] - low_q;
				default: ;
			endcase
		end
	end

	assign lo_r = ($signed({low_q[W-1], low_q}) + HALF16) >>> 16;

	always_comb begin
		if (lo_r > SAT_HI) begin
			sat = 16'sh7fff;
		end else if (lo_r < SAT_LO) begin
			sat = 16'sh8000;
		end else begin
			sat = lo_r[15:0];
		end
	end

	assign out_free = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.adv && ctrl.uc.emit) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv && ctrl.uc.emit) begin
			out_q <= sat;
		end
	end

	assign result_valid = out_valid_q;
	assign sample_out   = out_q;

	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.adv && ctrl.uc.emit))
		else $error("result appeared without an emit step");

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.uc.emit && !ctrl.adv) |=> $stable(acc_q) && $stable(low_q))
		else $error("state changed while waiting on the output slot");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for state_variable_lowpass: directed rows and random phases against a predictor.
module tb_top;
	import svl_pkg::*;

	localparam int STATE_W = 36;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS = 55;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef logic signed [STATE_W-1:0] acc_t;
	typedef logic signed [15:0] pcm_t;

	typedef enum logic {
		ROW_SAMPLE,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  idx;
		logic [15:0] val;
		logic        fixed;
		pcm_t        want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_stall;
	pcm_t        sample_in = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	pcm_t        sample_out;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// predictor state
	acc_t        low_acc = '0;
	acc_t        band_acc = '0;
	logic [14:0] coef_freq = 15'd16384;
	logic [15:0] coef_damp = 16'd32768;
	logic [15:0] coef_gain = 16'd32768;

	pcm_t pending_outputs[$];
	int   errors = 0;
	int   cycle_count = 0;

	plan_row_t plan [25] = '{
		'{ROW_WRITE,  REG_FREQ,   16'd0,     1'b0, 16'sd0},
		// f = 0 and low still at reset: output stays zero
		'{ROW_SAMPLE, 2'd0,       16'h7FFF,  1'b1, 16'sd0},
		'{ROW_SAMPLE, 2'd0,       16'h8000,  1'b1, 16'sd0},
		'{ROW_SAMPLE, 2'd0,       16'd12345, 1'b1, 16'sd0},
		'{ROW_WRITE,  REG_FREQ,   16'd16384, 1'b0, 16'sd0},
		'{ROW_SAMPLE, 2'd0,       16'h0000,  1'b0, 16'sd0},
		'{ROW_SAMPLE, 2'd0,       16'h0001,  1'b0, 16'sd0},
		'{ROW_SAMPLE, 2'd0,       16'hFFFF,  1'b0, 16'sd0},
		'{ROW_WRITE,  REG_DAMP,   16'd0,     1'b0, 16'sd0},
		'{ROW_SAMPLE, 2'd0,       16'h7FFF,  1'b0, 16'sd0},
		'{ROW_SAMPLE, 2'd0,       16'h7FFF,  1'b0, 16'sd0},
		'{ROW_WRITE,  REG_DAMP,   16'hFFFF,  1'b0, 16'sd0},
		'{ROW_WRITE,  REG_GAIN,   16'hFFFF,  1'b0, 16'sd0},
		'{ROW_SAMPLE, 2'd0,       16'h8000,  1'b0, 16'sd0},
		'{ROW_SAMPLE, 2'd0,       16'h8000,  1'b0, 16'sd0},
		// freq above range, top bit dropped
		'{ROW_WRITE,  REG_FREQ,   16'hFFFF,  1'b0, 16'sd0},
		'{ROW_SAMPLE, 2'd0,       16'd1000,  1'b0, 16'sd0},
		'{ROW_SAMPLE, 2'd0,       16'hFC18,  1'b0, 16'sd0},
		// unknown index, no effect
		'{ROW_WRITE,  REG_UNUSED, 16'h1234,  1'b0, 16'sd0},
		'{ROW_WRITE,  REG_FREQ,   16'd8192,  1'b0, 16'sd0},
		'{ROW_SAMPLE, 2'd0,       16'h8000,  1'b0, 16'sd0},
		'{ROW_WRITE,  REG_GAIN,   16'd0,     1'b0, 16'sd0},
		'{ROW_SAMPLE, 2'd0,       16'd21845, 1'b0, 16'sd0},
		'{ROW_WRITE,  REG_DAMP,   16'd32768, 1'b0, 16'sd0},
		'{ROW_SAMPLE, 2'd0,       16'h0000,  1'b0, 16'sd0}
	};

	state_variable_lowpass dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_in    (sample_in),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sample_out   (sample_out),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// round to nearest, ties up, dropping k bits
	function automatic longint round_off(longint v, int k);
		return (v + (longint'(1) <<< (k - 1))) >>> k;
	endfunction

	function automatic pcm_t lowpass_step(pcm_t x);
		longint lo;
		longint hi;
		longint bd;
		longint y;
		acc_t   lo_w;
		acc_t   hi_w;
		lo = longint'(low_acc) + round_off(longint'(coef_freq) * longint'(band_acc), 14);
		lo_w = lo[STATE_W-1:0];
		hi = longint'(coef_gain) * longint'(x) * 2
			- round_off(longint'(coef_damp) * longint'(band_acc), 15) - longint'(lo_w);
		hi_w = hi[STATE_W-1:0];
		bd = longint'(band_acc) + round_off(longint'(coef_freq) * longint'(hi_w), 14);
		low_acc = lo_w;
		band_acc = bd[STATE_W-1:0];
		y = round_off(longint'(lo_w), 16);
		if (y > 32767)
			y = 32767;
		else if (y < -32768)
			y = -32768;
		return pcm_t'(y);
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t mismatch: %s", $time, msg);
		errors++;
	endtask

	// leaves cfg_we high so back-to-back writes need one assignment per edge
	task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_FREQ: coef_freq = val[14:0];
			REG_DAMP: coef_damp = val;
			REG_GAIN: coef_gain = val;
			default: ;
		endcase
	endtask

	task automatic send_sample(pcm_t x, logic fixed, pcm_t want);
		pcm_t got;
		sample_valid <= 1'b1;
		sample_in <= x;
		do
			@(posedge clk);
		while (sample_stall);
		got = lowpass_step(x);
		pending_outputs.push_back(fixed ? want : got);
	endtask

	task automatic settle();
		sample_valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic pcm_t pick_sample(int style, int n, int period);
		case (style)
			0: return pcm_t'($urandom);
			1: begin
				case ($urandom_range(0, 2))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					default: return 16'sh0000;
				endcase
			end
			2: return pcm_t'(int'($urandom_range(0, 400)) - 200);
			default: return ((n / period) % 2) ? 16'sh7FFF : 16'sh8000;
		endcase
	endfunction

	task automatic pick_coefs(int phase);
		logic [15:0] f;
		logic [15:0] d;
		logic [15:0] g;
		if (phase == RANDOM_PHASES - 1) begin
			// wild setting to drive the integrators through wraparound
			f = 16'h7FFF;
			d = 16'd0;
			g = 16'hFFFF;
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					f = 16'($urandom_range(0, 16384));
					d = 16'($urandom_range(8192, 32768));
					g = 16'($urandom_range(0, 32768));
				end
				1: begin
					f = $urandom_range(0, 1) ? 16'd16384 : 16'd0;
					d = $urandom_range(0, 1) ? 16'd32768 : 16'hFFFF;
					g = $urandom_range(0, 1) ? 16'd32768 : 16'hFFFF;
				end
				2: begin
					f = 16'($urandom);
					d = 16'($urandom);
					g = 16'($urandom);
				end
				default: begin
					f = 16'($urandom_range(0, 4096));
					d = 16'($urandom_range(0, 65535));
					g = 16'd32768;
				end
			endcase
		end
		cfg_write(REG_FREQ, f);
		cfg_write(REG_DAMP, d);
		cfg_write(REG_GAIN, g);
		if ($urandom_range(0, 3) == 0)
			cfg_write(REG_UNUSED, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	initial begin
		bit cfg_open;
		int burst_left;
		int gap;
		int style;
		int period;
		bit no_gaps;
		cfg_open = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				if (!cfg_open)
					settle();
				cfg_write(plan[i].idx, plan[i].val);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open) begin
					cfg_we <= 1'b0;
					cfg_open = 1'b0;
				end
				send_sample(pcm_t'(plan[i].val), plan[i].fixed, plan[i].want);
			end
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			pick_coefs(p);
			style = $urandom_range(0, 3);
			period = $urandom_range(2, 24);
			no_gaps = ($urandom_range(0, 3) == 0);
			burst_left = $urandom_range(1, 20);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_sample(pick_sample(($urandom_range(0, 4) == 0) ? 0 : style, n, period),
					1'b0, 16'sd0);
				burst_left--;
				if (!no_gaps && burst_left == 0) begin
					gap = $urandom_range(0, 8);
					if (gap > 0) begin
						sample_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
					burst_left = $urandom_range(1, 20);
				end
			end
		end

		settle();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// receiver stall pattern in one of three randomly picked modes
	always @(posedge clk) begin : stall_gen
		int mode;
		int tick;
		if (tick % 150 == 0)
			mode = $urandom_range(0, 2);
		case (mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			default: result_stall <= (tick % 16) < 9;
		endcase
		tick++;
	end

	always @(posedge clk) begin : check_out
		pcm_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_outputs.size() == 0) begin
				report_mismatch($sformatf("sample_out %0d with nothing pending", sample_out));
			end else begin
				want = pending_outputs.pop_front();
				if (sample_out !== want)
					report_mismatch($sformatf("sample_out %0d, want %0d", sample_out, want));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

endmodule
